// ===== rtl/core/mbet_pkg.sv =====
`default_nettype none

package mbet_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 16;

    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int Q_BITS     = FRAC_BITS + 4;
    localparam int PROD_BITS  = 2 * Q_BITS;
    localparam int NUM_BITS   = COORD_BITS + 2;
    localparam int QUO_BITS   = NUM_BITS + FRAC_BITS;
    localparam int STEP_BITS  = $clog2(QUO_BITS);
    localparam int SHADE_BITS = ITER_BITS + 5;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = (SIZE_BITS > ITER_BITS) ? SIZE_BITS : ITER_BITS;

    localparam int IN_FIELD_BITS  = 2 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + ITER_BITS + SHADE_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH    = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT   = CFG_ADDR_BITS'(1);
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_ITERATIONS = CFG_ADDR_BITS'(2);

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
    localparam logic [ITER_BITS-1:0] LIMIT_RESET  = ITER_BITS'(256);

    typedef struct packed {
        logic load;
        logic div_step;
        logic map;
        logic mul;
        logic update;
        logic out_load;
    } mbet_cmd_t;

    typedef struct packed {
        logic limit_hit;
        logic escaped;
    } mbet_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time_pixel_top.sv =====
// Flow: an accepted pixel runs a bit-serial restoring divide for both coordinates, then the
// mapping step, then the shared multiply/update loop until the limit stops the pixel or it
// escapes; the result then waits in the done state until the output stage is free.
// Throughput: one pixel at a time, the next is accepted only once the result is in the output
// stage; a held result does not block the next pixel until its own result is ready.
// Reset: rst_n async active low; registers return to 640 / 480 / 256, output stage empty.
`default_nettype none

module mandelbrot_escape_time_pixel_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // column, row
    input  wire logic [mbet_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // out_column, out_row, iteration_count, shade, zero pad
    output logic      [mbet_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [mbet_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [mbet_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import mbet_pkg::*;

    logic [SIZE_BITS-1:0]     width_reg;
    logic [SIZE_BITS-1:0]     height_reg;
    logic [ITER_BITS-1:0]     limit_reg;
    logic                     m_valid_reg;
    logic [OUT_DATA_BITS-1:0] m_data_reg;

    mbet_cmd_t                cmd;
    mbet_sts_t                sts;
    logic                     out_free;
    logic [COORD_BITS-1:0]    res_column;
    logic [COORD_BITS-1:0]    res_row;
    logic [ITER_BITS-1:0]     res_count;
    logic [SHADE_BITS-1:0]    res_shade;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_wdata[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= cfg_wdata[SIZE_BITS-1:0];
                REG_MAX_ITERATIONS: limit_reg  <= cfg_wdata[ITER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    mbet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbet_dp u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .sts             (sts),
        .column          (s_axis_tdata[COORD_BITS-1:0]),
        .row             (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .image_width     (width_reg),
        .image_height    (height_reg),
        .max_iterations  (limit_reg),
        .out_column      (res_column),
        .out_row         (res_row),
        .iteration_count (res_count),
        .shade           (res_shade)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            m_data_reg <= OUT_DATA_BITS'({res_shade, res_count, res_row, res_column});
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mbet_dp.sv =====
`default_nettype none

module mbet_dp (
    input  wire logic                             clk,
    input  wire mbet_pkg::mbet_cmd_t              cmd,
    output mbet_pkg::mbet_sts_t                   sts,
    input  wire logic [mbet_pkg::COORD_BITS-1:0]  column,
    input  wire logic [mbet_pkg::COORD_BITS-1:0]  row,
    input  wire logic [mbet_pkg::SIZE_BITS-1:0]   image_width,
    input  wire logic [mbet_pkg::SIZE_BITS-1:0]   image_height,
    input  wire logic [mbet_pkg::ITER_BITS-1:0]   max_iterations,
    output logic      [mbet_pkg::COORD_BITS-1:0]  out_column,
    output logic      [mbet_pkg::COORD_BITS-1:0]  out_row,
    output logic      [mbet_pkg::ITER_BITS-1:0]   iteration_count,
    output logic      [mbet_pkg::SHADE_BITS-1:0]  shade
);
    import mbet_pkg::*;

    localparam int EXT_BITS    = Q_BITS + 2;
    localparam int QI_BITS     = 5;
    localparam int INT_CAP     = 16;
    localparam int SHADE_SCALE = 25;

    localparam logic signed [PROD_BITS-1:0] Q_MAX_P =
        PROD_BITS'((64'sd1 <<< (Q_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] Q_MIN_P =
        PROD_BITS'(-(64'sd1 <<< (Q_BITS - 1)));
    localparam logic signed [EXT_BITS-1:0] BASE_RE = EXT_BITS'(-(64'sd2 <<< FRAC_BITS));
    localparam logic signed [EXT_BITS-1:0] BASE_IM = EXT_BITS'(-(64'sd1 <<< FRAC_BITS));
    localparam logic signed [Q_BITS:0]     ESC_LIMIT = (Q_BITS + 1)'(64'sd4 <<< FRAC_BITS);

    function automatic logic signed [Q_BITS-1:0] sat(input logic signed [PROD_BITS-1:0] v);
        logic signed [Q_BITS-1:0] r;
        if (v > Q_MAX_P)
            r = $signed(Q_MAX_P[Q_BITS-1:0]);
        else if (v < Q_MIN_P)
            r = $signed(Q_MIN_P[Q_BITS-1:0]);
        else
            r = $signed(v[Q_BITS-1:0]);
        return r;
    endfunction

    // restoring divide, one quotient bit per call
    function automatic logic [SIZE_BITS+QUO_BITS-1:0] div_step(
        input logic [SIZE_BITS-1:0] rem,
        input logic [QUO_BITS-1:0]  quo,
        input logic [SIZE_BITS-1:0] den
    );
        logic [SIZE_BITS:0] trial;
        logic [SIZE_BITS:0] diff;
        logic [SIZE_BITS+QUO_BITS-1:0] r;
        trial = {rem, quo[QUO_BITS-1]};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
            r = {diff[SIZE_BITS-1:0], quo[QUO_BITS-2:0], 1'b1};
        else
            r = {trial[SIZE_BITS-1:0], quo[QUO_BITS-2:0], 1'b0};
        return r;
    endfunction

    function automatic logic signed [Q_BITS-1:0] map_coord(
        input logic signed [EXT_BITS-1:0] base,
        input logic [QUO_BITS-1:0]        quo
    );
        logic [NUM_BITS-1:0]        qi;
        logic [QI_BITS-1:0]         qc;
        logic signed [EXT_BITS-1:0] sum;
        qi  = quo[QUO_BITS-1:FRAC_BITS];
        qc  = (qi > NUM_BITS'(INT_CAP)) ? QI_BITS'(INT_CAP) : qi[QI_BITS-1:0];
        sum = base + $signed({1'b0, qc, quo[FRAC_BITS-1:0]});
        return sat(PROD_BITS'(sum));
    endfunction

    logic [COORD_BITS-1:0]        col_reg;
    logic [COORD_BITS-1:0]        row_reg;
    logic [QUO_BITS-1:0]          quo_re_reg;
    logic [QUO_BITS-1:0]          quo_im_reg;
    logic [SIZE_BITS-1:0]         rem_re_reg;
    logic [SIZE_BITS-1:0]         rem_im_reg;
    logic signed [Q_BITS-1:0]     cr_reg;
    logic signed [Q_BITS-1:0]     ci_reg;
    logic signed [Q_BITS-1:0]     zr_reg;
    logic signed [Q_BITS-1:0]     zi_reg;
    logic signed [PROD_BITS-1:0]  prr_reg;
    logic signed [PROD_BITS-1:0]  pii_reg;
    logic signed [PROD_BITS-1:0]  pri_reg;
    logic [ITER_BITS-1:0]         k_reg;

    logic [SIZE_BITS-1:0]         den_re;
    logic [SIZE_BITS-1:0]         den_im;
    logic [NUM_BITS-1:0]          num_re;
    logic [NUM_BITS-1:0]          num_im;
    logic signed [Q_BITS-1:0]     rr;
    logic signed [Q_BITS-1:0]     ii;
    logic signed [Q_BITS-1:0]     ri;
    logic signed [Q_BITS:0]       mag;
    logic signed [Q_BITS-1:0]     zr_new;
    logic signed [Q_BITS-1:0]     zi_new;
    logic [ITER_BITS-1:0]         left;

    always_comb
    begin
        den_re = (image_width  <= SIZE_BITS'(1)) ? SIZE_BITS'(1) : image_width  - SIZE_BITS'(1);
        den_im = (image_height <= SIZE_BITS'(1)) ? SIZE_BITS'(1) : image_height - SIZE_BITS'(1);
        num_re = NUM_BITS'({column, 1'b0}) + NUM_BITS'(column);
        num_im = NUM_BITS'({row, 1'b0});

        rr     = sat(prr_reg >>> FRAC_BITS);
        ii     = sat(pii_reg >>> FRAC_BITS);
        // 2*re*im: take the product one bit further up
        ri     = sat(pri_reg >>> (FRAC_BITS - 1));
        mag    = (Q_BITS + 1)'(rr) + (Q_BITS + 1)'(ii);
        zr_new = sat(PROD_BITS'(rr) - PROD_BITS'(ii) + PROD_BITS'(cr_reg));
        zi_new = sat(PROD_BITS'(ri) + PROD_BITS'(ci_reg));

        left   = max_iterations - k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg    <= column;
            row_reg    <= row;
            quo_re_reg <= {num_re, {FRAC_BITS{1'b0}}};
            quo_im_reg <= {num_im, {FRAC_BITS{1'b0}}};
            rem_re_reg <= '0;
            rem_im_reg <= '0;
            zr_reg     <= '0;
            zi_reg     <= '0;
            k_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            {rem_re_reg, quo_re_reg} <= div_step(rem_re_reg, quo_re_reg, den_re);
            {rem_im_reg, quo_im_reg} <= div_step(rem_im_reg, quo_im_reg, den_im);
        end
        if (cmd.map)
        begin
            cr_reg <= map_coord(BASE_RE, quo_re_reg);
            ci_reg <= map_coord(BASE_IM, quo_im_reg);
        end
        if (cmd.mul)
        begin
            prr_reg <= zr_reg * zr_reg;
            pii_reg <= zi_reg * zi_reg;
            pri_reg <= zr_reg * zi_reg;
        end
        if (cmd.update)
        begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
            k_reg  <= k_reg + ITER_BITS'(1);
        end
    end

    assign sts.limit_hit   = (k_reg >= max_iterations);
    assign sts.escaped     = (mag >= ESC_LIMIT);
    assign out_column      = col_reg;
    assign out_row         = row_reg;
    assign iteration_count = k_reg;
    assign shade           = SHADE_BITS'(left) * SHADE_BITS'(SHADE_SCALE);

endmodule

`default_nettype wire

// ===== rtl/core/mbet_ctrl.sv =====
`default_nettype none

module mbet_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  out_free,
    input  wire mbet_pkg::mbet_sts_t   sts,
    output mbet_pkg::mbet_cmd_t        cmd
);
    import mbet_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MAP,
        S_MUL,
        S_UPD,
        S_DONE
    } state_t;

    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(QUO_BITS - 1);

    state_t               state_reg;
    state_t               state_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_LAST)
                    state_next = S_MAP;
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (sts.limit_hit)
                    state_next = S_DONE;
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (sts.escaped)
                    state_next = S_DONE;
                else
                begin
                    cmd.update = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == STEP_LAST) |=> (state_reg == S_MAP))
        else $error("divide did not end after the last quotient bit");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg <= STEP_LAST))
        else $error("divide step count out of range");

    a_map_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAP) |=> (state_reg == S_MUL))
        else $error("iteration did not start after mapping");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=> (state_reg == S_DONE && !cmd.load))
        else $error("result dropped while output stage full");

endmodule

`default_nettype wire

// ===== tb/mandelbrot_pixel_checker.sv =====
`timescale 1ns / 1ps

module mandelbrot_pixel_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    // column, row
    input  wire logic [mbet_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_column, out_row, iteration_count, shade, zero pad
    input  wire logic [mbet_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [mbet_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [mbet_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output int                                      pixels_in_flight,
    output int                                      mismatch_count
);
    import mbet_pkg::*;

    typedef struct packed {
        logic [SHADE_BITS-1:0] shade;
        logic [ITER_BITS-1:0]  count;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } pixel_word_t;

    localparam longint FX_MAX  = (longint'(1) <<< (Q_BITS - 1)) - 1;
    localparam longint FX_MIN  = -(longint'(1) <<< (Q_BITS - 1));
    localparam longint FX_FOUR = longint'(4) <<< FRAC_BITS;

    logic [SIZE_BITS-1:0] img_w;
    logic [SIZE_BITS-1:0] img_h;
    logic [ITER_BITS-1:0] iter_lim;
    pixel_word_t          expected_pixels[$];
    int                   mismatches;

    function automatic longint fx_clamp(input logic signed [95:0] v);
        if (v > 96'(FX_MAX))
            return FX_MAX;
        if (v < 96'(FX_MIN))
            return FX_MIN;
        return longint'(v);
    endfunction

    // exact product, floor to FRAC_BITS, saturate
    function automatic longint fx_mul(input longint a, input longint b);
        logic signed [95:0] wa;
        logic signed [95:0] wb;
        logic signed [95:0] p;
        wa = 96'(a);
        wb = 96'(b);
        p = (wa * wb) >>> FRAC_BITS;
        return fx_clamp(p);
    endfunction

    function automatic longint map_axis(input longint base, input longint unsigned num,
                                        input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        longint unsigned frac;
        if (den == 0)
            den = 1;
        q = num / den;
        r = num % den;
        if (q > 16)
            q = 16;
        frac = (r << FRAC_BITS) / den;
        return fx_clamp(96'(base + longint'((q << FRAC_BITS) + frac)));
    endfunction

    function automatic pixel_word_t escape_time(input logic [COORD_BITS-1:0] col,
                                                input logic [COORD_BITS-1:0] row);
        pixel_word_t     res;
        longint          cr;
        longint          ci;
        longint          zr;
        longint          zi;
        longint          rr;
        longint          ii;
        longint          ri;
        longint unsigned k;
        longint unsigned lim;
        longint unsigned wden;
        longint unsigned hden;
        wden = (img_w > 0) ? 64'(img_w) - 64'(1) : 64'(0);
        hden = (img_h > 0) ? 64'(img_h) - 64'(1) : 64'(0);
        lim = 64'(iter_lim);
        cr = map_axis(-(longint'(2) <<< FRAC_BITS), 64'(col) * 3, wden);
        ci = map_axis(-(longint'(1) <<< FRAC_BITS), 64'(row) * 2, hden);
        zr = 0;
        zi = 0;
        k = 0;
        while (k < lim) begin
            rr = fx_mul(zr, zr);
            ii = fx_mul(zi, zi);
            if (rr + ii >= FX_FOUR)
                break;
            ri = fx_mul(zr * 2, zi);
            zr = fx_clamp(96'(rr - ii + cr));
            zi = fx_clamp(96'(ri + ci));
            k++;
        end
        res.col = col;
        res.row = row;
        res.count = ITER_BITS'(k);
        res.shade = SHADE_BITS'((lim - k) * 25);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_word_t want;
        pixel_word_t got;
        if (!rst_n)
        begin
            img_w = WIDTH_RESET;
            img_h = HEIGHT_RESET;
            iter_lim = LIMIT_RESET;
            expected_pixels.delete();
            mismatches = 0;
            pixels_in_flight <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:    img_w = cfg_wdata[SIZE_BITS-1:0];
                    REG_IMAGE_HEIGHT:   img_h = cfg_wdata[SIZE_BITS-1:0];
                    REG_MAX_ITERATIONS: iter_lim = cfg_wdata[ITER_BITS-1:0];
                    default:            ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(escape_time(s_axis_tdata[COORD_BITS-1:0],
                                                      s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[OUT_FIELD_BITS-1:0];
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word col %0d row %0d count %0d shade %0d",
                                 $realtime, got.col, got.row, got.count, got.shade);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.col !== want.col || got.row !== want.row ||
                        got.count !== want.count || got.shade !== want.shade)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp col %0d row %0d count %0d shade %0d,",
                                      " got col %0d row %0d count %0d shade %0d"},
                                     $realtime, want.col, want.row, want.count, want.shade,
                                     got.col, got.row, got.count, got.shade);
                    end
                end
            end
            pixels_in_flight <= expected_pixels.size();
            mismatch_count <= mismatches;
        end
    end

endmodule

// ===== tb/mandelbrot_escape_time_pixel_top_test.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_top_test;
    import mbet_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = CFG_ADDR_BITS'(3);
    localparam int RANDOM_PIXELS = 1650;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    int                       pixels_in_flight;
    int                       mismatch_count;
    bit                       steady = 1'b0;
    logic [SIZE_BITS-1:0]     cur_w;
    logic [SIZE_BITS-1:0]     cur_h;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mandelbrot_escape_time_pixel_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    mandelbrot_pixel_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .pixels_in_flight (pixels_in_flight),
        .mismatch_count   (mismatch_count)
    );

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 100);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CFG_DATA_BITS'(2);
        if (r < 18)
            return CFG_DATA_BITS'(4096);
        if (r < 22)
            return CFG_DATA_BITS'($urandom_range(0, 1));
        if (r < 30)
            return CFG_DATA_BITS'($urandom);
        if (r < 65)
            return CFG_DATA_BITS'($urandom_range(2, 64));
        return CFG_DATA_BITS'($urandom_range(2, 4096));
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CFG_DATA_BITS'(0);
        if (r < 16)
            return CFG_DATA_BITS'(1);
        if (r < 80)
            return CFG_DATA_BITS'($urandom_range(2, 48));
        if (r < 92)
            return CFG_DATA_BITS'($urandom_range(49, 120));
        return CFG_DATA_BITS'($urandom_range(121, 300));
    endfunction

    // mostly inside the image, sometimes anywhere in the field
    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [SIZE_BITS-1:0] size);
        int hi;
        if ($urandom_range(0, 99) < 15)
            return COORD_BITS'($urandom);
        hi = (size > 1) ? int'(size) - 1 : 1;
        if (hi > 4095)
            hi = 4095;
        return COORD_BITS'($urandom_range(0, hi));
    endfunction

    task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row);
        int gap;
        gap = steady ? 0 : pick_idle();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row, col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixels_in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
                             input logic [CFG_DATA_BITS-1:0] lim);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_MAX_ITERATIONS, lim);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_w = w[SIZE_BITS-1:0];
        cur_h = h[SIZE_BITS-1:0];
    endtask

    // result side backpressure
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (steady)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = pick_idle();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int                       phase_items;
        int                       sent;
        logic [CFG_DATA_BITS-1:0] lim;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        cur_w = WIDTH_RESET;
        cur_h = HEIGHT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners, outside the image, one point in the set
        send_pixel(0, 0);
        send_pixel(639, 479);
        send_pixel(320, 240);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);

        // zero limit, smallest image, write to the unused index
        configure(2, 2, 0);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(4095, 4095);
        drain();
        write_reg(REG_SPARE, '1);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_pixel(1, 0);

        // size below two
        configure(0, 1, 20);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        send_pixel(7, 3);

        // full limit; c = 0 never escapes
        configure(4, 3, 16'hFFFF);
        send_pixel(2, 1);
        send_pixel(0, 0);
        send_pixel(3, 2);
        send_pixel(4095, 4095);

        // high register bits dropped
        configure(16'hFFFF, 16'hF000, 1);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 2048);

        configure(4096, 4096, 255);
        send_pixel(2047, 2047);
        send_pixel(4095, 2047);

        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            lim = pick_limit();
            configure(pick_size(), pick_size(), lim);
            phase_items = (lim > 120) ? 30 : $urandom_range(60, 180);
            for (int i = 0; i < phase_items; i++)
            begin
                if (i % 25 == 0)
                    steady <= ($urandom_range(0, 4) == 0);
                send_pixel(pick_coord(cur_w), pick_coord(cur_h));
            end
            sent += phase_items;
        end

        drain();
        steady <= 1'b0;
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("[mandelbrot_escape_time_pixel_top] OK");
        else
            $display("[mandelbrot_escape_time_pixel_top] ERROR");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("[mandelbrot_escape_time_pixel_top] ERROR");
        $finish;
    end

endmodule
